// ===== sv/asc_pkg.sv =====
// Shared widths, constants and control types for the accelerometer step counter.
package asc_pkg;

  // Sample and window geometry
  localparam int unsigned SAMPLE_W = 13;
  localparam int unsigned WINDOW   = 10;
  localparam int unsigned AXES     = 3;
  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Running sum and rounded-mean widths
  localparam int unsigned SUM_W   = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned U_W     = SUM_W + 2;
  localparam int unsigned A_W     = SUM_W + 1;
  localparam int unsigned RECIP_K = A_W;
  localparam int unsigned M_W     = RECIP_K + 1;
  localparam int unsigned PROD_W  = A_W + M_W;
  localparam logic [M_W-1:0] RECIP_M = M_W'((64'd1 << RECIP_K) / WINDOW);
  localparam logic [A_W-1:0] WIN_A   = A_W'(WINDOW);
  localparam logic [U_W-1:0] WIN_U   = U_W'(WINDOW);

  // Magnitude path
  localparam int unsigned MEAN_W     = SAMPLE_W;
  localparam int unsigned SQ_W       = 2 * MEAN_W;
  localparam int unsigned MAG_W      = SQ_W / 2;
  localparam int unsigned ROOT_ITERS = SQ_W / 2;
  localparam int unsigned ROOT_CNT_W = $clog2(ROOT_ITERS);
  localparam int unsigned REM_W      = MAG_W + 2;

  // Step logic and configuration
  localparam int unsigned THR_W     = 13;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = THR_W;
  localparam logic [CFG_IDX_W-1:0] REG_START_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_THR   = 1'd1;
  localparam logic [THR_W-1:0] START_THR_RST = 13'd268;
  localparam logic [THR_W-1:0] END_THR_RST   = 13'd256;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [AXIS_W-1:0]          axis_t;
  typedef logic [THR_W-1:0]           thr_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic  capture;
    logic  read_old;
    logic  update;
    logic  do_abs;
    logic  do_mul;
    logic  do_fix;
    logic  do_sqr;
    logic  root_start;
    logic  root_step;
    logic  decide;
    axis_t axis;
  } asc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic root_last;
    logic out_full;
  } asc_sts_t;

endpackage

// ===== sv/accel_step_counter.sv =====
// Top level of the accelerometer step counter: configuration registers and unit wiring.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one three-axis sample per
//   transaction. Output channel (out_valid_o / out_ready_i) returns one result
//   per sample: the wrapping step count, the in-step flag and the magnitude
//   of the moving-average vector.
//   Thresholds are written through cfg_we_i / cfg_index_i / cfg_data_i while
//   the block is idle: index 0 is the start threshold, index 1 the end one.
//   A new sample is accepted only after the decision for the previous one
//   has been made. The processing time is set by the shared mean/square
//   unit, which makes four passes per axis over the three axes, and the
//   13-step bit-serial square root.
//   Reset clears the window (entries not yet written read as zero), the step
//   count and re-arms the detector; thresholds return to 268 and 256.
//   When the receiver stalls, the finished result holds in the output
//   register; the next sample is still accepted and processed, and its
//   decision waits until the output register is free.
module accel_step_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  asc_pkg::sample_t              accel_x_i,
  input  asc_pkg::sample_t              accel_y_i,
  input  asc_pkg::sample_t              accel_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [asc_pkg::COUNT_W-1:0]   step_count_o,
  output logic                          in_step_o,
  output logic [asc_pkg::MAG_W-1:0]     magnitude_o,
  input  logic                          cfg_we_i,
  input  logic [asc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [asc_pkg::CFG_W-1:0]     cfg_data_i
);
  import asc_pkg::*;

  thr_t     start_thr_q;
  thr_t     end_thr_q;
  asc_cmd_t cmd;
  asc_sts_t sts;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_thr_q <= START_THR_RST;
      end_thr_q   <= END_THR_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_START_THR) begin
        start_thr_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_END_THR) begin
        end_thr_q <= cfg_data_i;
      end
    end
  end

  asc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  asc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .start_thr_i  (start_thr_q),
    .end_thr_i    (end_thr_q),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .step_count_o (step_count_o),
    .in_step_o    (in_step_o),
    .magnitude_o  (magnitude_o)
  );

endmodule

// ===== sv/asc_isqrt.sv =====
// Bit-serial floor square root, one result bit per step.
module asc_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      step_i,
  input  logic [asc_pkg::SQ_W-1:0]  value_i,
  output logic                      last_o,
  output logic [asc_pkg::MAG_W-1:0] root_o
);
  import asc_pkg::*;

  localparam logic [ROOT_CNT_W-1:0] LAST_CNT = ROOT_CNT_W'(ROOT_ITERS - 1);

  logic [ROOT_CNT_W-1:0] cnt_q, cnt_d;
  logic [SQ_W-1:0]       val_q;
  logic [REM_W-1:0]      rem_q;
  logic [MAG_W-1:0]      root_q;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic                  fits;

  // Bring in the next two radicand bits and test the trial divisor
  assign rem_sh = {rem_q[REM_W-3:0], val_q[SQ_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = '0;
    end else if (step_i) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Hold the iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Advance the radicand, remainder and partial root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (step_i) begin
      val_q <= {val_q[SQ_W-3:0], 2'b00};
      if (fits) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign last_o = (cnt_q == LAST_CNT);
  assign root_o = root_q;

endmodule

// ===== sv/asc_datapath.sv =====
// Window store, running sums, mean and square unit, root unit and step decision.
module asc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  asc_pkg::asc_cmd_t           cmd_i,
  output asc_pkg::asc_sts_t           sts_o,
  input  asc_pkg::sample_t            accel_x_i,
  input  asc_pkg::sample_t            accel_y_i,
  input  asc_pkg::sample_t            accel_z_i,
  input  asc_pkg::thr_t               start_thr_i,
  input  asc_pkg::thr_t               end_thr_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [asc_pkg::COUNT_W-1:0] step_count_o,
  output logic                        in_step_o,
  output logic [asc_pkg::MAG_W-1:0]   magnitude_o
);
  import asc_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  // Captured sample and window store
  sample_t                   samp_q [AXES];
  logic [AXES*SAMPLE_W-1:0]  win_mem [WINDOW];
  logic [AXES*SAMPLE_W-1:0]  rd_q;
  logic [SLOT_W-1:0]         slot_q;
  logic                      filled_q;
  sum_t                      sum_q [AXES];
  sum_t                      sum_d [AXES];
  sample_t                   old_s [AXES];

  // Mean and square unit
  sum_t                      sel_sum;
  logic [U_W-1:0]            u_s;
  logic [U_W-1:0]            u_abs;
  logic [A_W-1:0]            a_q;
  logic [PROD_W-1:0]         a_ext;
  logic [PROD_W-1:0]         m_ext;
  logic [PROD_W-1:0]         prod_q;
  logic [A_W-1:0]            q0;
  logic [A_W-1:0]            qn;
  logic [A_W-1:0]            rem;
  logic [A_W-1:0]            q_fix;
  logic [MEAN_W-1:0]         q_q;
  logic [SQ_W-1:0]           q_ext;
  logic [SQ_W-1:0]           acc_q;

  // Root and step decision
  logic [MAG_W-1:0]          root;
  logic                      root_last;
  logic [COUNT_W-1:0]        steps_q, steps_n;
  logic                      armed_q, armed_n;
  logic                      out_valid_q;
  logic [COUNT_W-1:0]        step_count_q;
  logic                      in_step_q;
  logic [MAG_W-1:0]          mag_q;
  logic                      out_full;
  logic [SQ_W+1:0]           chk_lo;
  logic [SQ_W+1:0]           chk_hi;

  // Capture the sample, read the entry to be replaced and write the new one
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      samp_q[0] <= accel_x_i;
      samp_q[1] <= accel_y_i;
      samp_q[2] <= accel_z_i;
    end
    if (cmd_i.read_old) begin
      rd_q <= win_mem[slot_q];
    end
    if (cmd_i.update) begin
      win_mem[slot_q] <= {samp_q[2], samp_q[1], samp_q[0]};
    end
  end

  // Entries not yet written count as zero
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      old_s[a] = filled_q ? sample_t'(rd_q[a*SAMPLE_W +: SAMPLE_W]) : '0;
      sum_d[a] = sum_q[a] + SUM_W'(samp_q[a]) - SUM_W'(old_s[a]);
    end
  end

  // Advance the slot pointer and the running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      filled_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= '0;
      end
    end else if (cmd_i.update) begin
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= sum_d[a];
      end
      if (slot_q == LAST_SLOT) begin
        slot_q   <= '0;
        filled_q <= 1'b1;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  // Magnitude of the rounded-mean numerator, halved toward zero
  assign sel_sum = sum_q[cmd_i.axis];
  assign u_s     = {sel_sum[SUM_W-1], sel_sum, 1'b0} + WIN_U;
  assign u_abs   = u_s[U_W-1] ? (~u_s + 1'b1) : u_s;

  // Reciprocal multiply, then one correction step
  assign a_ext = PROD_W'(a_q);
  assign m_ext = PROD_W'(RECIP_M);
  assign q0    = prod_q[RECIP_K +: A_W];
  assign qn    = q0 * WIN_A;
  assign rem   = a_q - qn;
  assign q_fix = (rem >= WIN_A) ? (q0 + 1'b1) : q0;
  assign q_ext = SQ_W'(q_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_abs) begin
      a_q <= u_abs[U_W-1:1];
    end
    if (cmd_i.do_mul) begin
      prod_q <= a_ext * m_ext;
    end
    if (cmd_i.do_fix) begin
      q_q <= MEAN_W'(q_fix);
    end
    if (cmd_i.capture) begin
      acc_q <= '0;
    end else if (cmd_i.do_sqr) begin
      acc_q <= acc_q + q_ext * q_ext;
    end
  end

  asc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_start),
    .step_i  (cmd_i.root_step),
    .value_i (acc_q),
    .last_o  (root_last),
    .root_o  (root)
  );

  // Count a step on a rise above start, re-arm below end
  always_comb begin
    steps_n = steps_q;
    armed_n = armed_q;
    if (root > MAG_W'(start_thr_i)) begin
      if (armed_q) begin
        steps_n = steps_q + 1'b1;
      end
      armed_n = 1'b0;
    end
    if (root < MAG_W'(end_thr_i)) begin
      armed_n = 1'b1;
    end
  end

  assign out_full = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q     <= '0;
      armed_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.decide) begin
        steps_q     <= steps_n;
        armed_q     <= armed_n;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result transaction until it is taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      step_count_q <= steps_n;
      in_step_q    <= ~armed_n;
      mag_q        <= root;
    end
  end

  assign sts_o.root_last = root_last;
  assign sts_o.out_full  = out_full;
  assign out_valid_o     = out_valid_q;
  assign step_count_o    = step_count_q;
  assign in_step_o       = in_step_q;
  assign magnitude_o     = mag_q;

  assign chk_lo = (SQ_W+2)'(root) * (SQ_W+2)'(root);
  assign chk_hi = ((SQ_W+2)'(root) + 1'b1) * ((SQ_W+2)'(root) + 1'b1);

  // The root is the floor square root of the summed squares
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> (chk_lo <= (SQ_W+2)'(acc_q)) && (chk_hi > (SQ_W+2)'(acc_q)))
    else $error("root is not the floor square root of the accumulator");

  // A decision never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> !out_full)
    else $error("result overwritten while stalled");

  // Once the window has wrapped it stays filled
  a_filled_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q |=> filled_q)
    else $error("window fill flag dropped");

endmodule

// ===== sv/asc_ctrl.sv =====
// Sequencer that steps one sample through update, mean, square, root and decision.
module asc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  asc_pkg::asc_sts_t sts_i,
  output asc_pkg::asc_cmd_t cmd_o
);
  import asc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_READ   = 9'b000000010,
    S_UPDATE = 9'b000000100,
    S_ABS    = 9'b000001000,
    S_MUL    = 9'b000010000,
    S_FIX    = 9'b000100000,
    S_SQR    = 9'b001000000,
    S_START  = 9'b010000000,
    S_ROOT   = 9'b100000000
  } state_e;

  localparam axis_t LAST_AXIS = AXIS_W'(AXES - 1);

  state_e state_q, state_d;
  axis_t  axis_q, axis_d;
  logic   deciding_q, deciding_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    deciding_d = deciding_q;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (deciding_q) begin
          // Wait for room in the output register
          if (!sts_i.out_full) begin
            cmd_o.decide = 1'b1;
            deciding_d   = 1'b0;
          end
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.read_old = 1'b1;
        state_d        = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        axis_d       = '0;
        state_d      = S_ABS;
      end
      S_ABS: begin
        cmd_o.do_abs = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.do_mul = 1'b1;
        state_d      = S_FIX;
      end
      S_FIX: begin
        cmd_o.do_fix = 1'b1;
        state_d      = S_SQR;
      end
      S_SQR: begin
        cmd_o.do_sqr = 1'b1;
        if (axis_q == LAST_AXIS) begin
          state_d = S_START;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_ABS;
        end
      end
      S_START: begin
        cmd_o.root_start = 1'b1;
        state_d          = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_last) begin
          deciding_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      axis_q     <= '0;
      deciding_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      axis_q     <= axis_d;
      deciding_q <= deciding_d;
    end
  end

  // An accepted sample always starts the window read
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_READ))
    else $error("accepted transaction did not start processing");

  // The last root step hands over to the decision
  a_root_to_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT && sts_i.root_last) |=> (state_q == S_IDLE && deciding_q))
    else $error("root finished without a pending decision");

endmodule
